/* rtl/box_filter_5x5_replicate_unit_assert.svh */
// Assertion macros for the 5x5 box filter unit.
// Used by the port checker; no other dependencies.
`ifndef BOX_FILTER_5X5_REPLICATE_UNIT_ASSERT_SVH
`define BOX_FILTER_5X5_REPLICATE_UNIT_ASSERT_SVH

// same-cycle implication, masked during reset
`define BF5_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked during reset
`define BF5_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, also checked through reset
`define BF5_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/bf5_pkg.sv */
// Shared constants, types and the column-sum function of the 5x5 box filter.
// No dependencies.
package bf5_pkg;

  localparam int MAX_WIDTH     = 2048;
  localparam int KERNEL_RADIUS = 2;
  localparam int KSIZE         = 2 * KERNEL_RADIUS + 1;
  localparam int RING_ROWS     = 8;
  localparam int LANE_W        = $clog2(RING_ROWS);
  localparam int COL_W         = $clog2(MAX_WIDTH);
  localparam int EW_W          = COL_W + 1;
  localparam int LAG_W         = COL_W + 2;
  localparam int WID_W         = 12;
  localparam int HGT_W         = 16;
  localparam int RW            = HGT_W + 1;
  localparam int CH_W          = 8;
  localparam int NCH           = 3;
  localparam int PIX_W         = NCH * CH_W;
  localparam int CSUM_W        = CH_W + $clog2(KSIZE);
  localparam int TSUM_W        = CH_W + $clog2(KSIZE * KSIZE);
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;

  // floor(x/25) = (x * 5243) >> 17 for x <= 25*255
  localparam logic [TSUM_W-1:0] DIV_MUL = TSUM_W'(5243);
  localparam int DIV_SHIFT = 17;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = FIFO_AW + 1;

  // register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_COLOR  = 2'd2;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [RING_ROWS-1:0][PIX_W-1:0] column_t;
  typedef logic [KSIZE-1:0][LANE_W-1:0] lanes_t;
  typedef logic [NCH-1:0][CSUM_W-1:0] csum_t;

  typedef struct packed {
    logic   first;
    logic   last;
    logic   one_wide;
    lanes_t lanes;
  } emit_ctl_t;

  typedef struct packed {
    logic                      last;
    logic [NCH-1:0][CH_W-1:0]  ch;
  } out_ent_t;

  // sum of the five selected ring rows of one column, per channel
  function automatic csum_t col_sum(input column_t col, input lanes_t lanes);
    csum_t acc;
    acc = '0;
    for (int k = 0; k < KSIZE; k++) begin
      for (int c = 0; c < NCH; c++) begin
        acc[c] = acc[c] + CSUM_W'(col[lanes[k]][c*CH_W +: CH_W]);
      end
    end
    return acc;
  endfunction

endpackage

/* rtl/box_filter_5x5_replicate_unit.sv */
// 5x5 mean filter with replicated border. Throughput: one request per cycle,
// set by the line store, written and read once per request; in_tready drops
// only while eight results are outstanding. Reset (rst_n low, synchronous)
// restores register defaults, restarts the frame and empties the pipeline and
// output queue; the line store keeps data. Needs bf5_pkg.
module box_filter_5x5_replicate_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [23:0]               in_tdata,   // chan0_in, chan1_in, chan2_in
  input  logic                      in_tuser,   // func
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [23:0]               out_tdata,  // chan0_out, chan1_out, chan2_out
  output logic                      out_tlast,  // frame_last
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [bf5_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [bf5_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [bf5_pkg::DATA_W-1:0] cfg_prdata,
  output logic                      cfg_pready
);
  import bf5_pkg::*;

  // configuration registers
  logic [WID_W-1:0] image_width_r;
  logic [HGT_W-1:0] image_height_r;
  logic             color_mode_r;
  logic             cfg_wr;
  logic [1:0]       reg_idx;
  logic             cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[ADDR_W-1:2];
  assign cfg_hit    = cfg_wr && (reg_idx == REG_WIDTH || reg_idx == REG_HEIGHT ||
                                 reg_idx == REG_COLOR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WID_W'(640);
      image_height_r <= HGT_W'(480);
      color_mode_r   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WIDTH:  image_width_r  <= cfg_pwdata[WID_W-1:0];
        REG_HEIGHT: image_height_r <= cfg_pwdata[HGT_W-1:0];
        REG_COLOR:  color_mode_r   <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  cfg_prdata = DATA_W'(image_width_r);
      REG_HEIGHT: cfg_prdata = DATA_W'(image_height_r);
      REG_COLOR:  cfg_prdata = DATA_W'(color_mode_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // effective image size
  logic [31:0]      w_raw;
  logic [EW_W-1:0]  w_eff, wm1;
  logic [HGT_W-1:0] h_eff, hm1;

  assign w_raw = 32'(image_width_r);
  always_comb begin
    if (w_raw == 32'd0)                 w_eff = EW_W'(1);
    else if (w_raw > 32'(MAX_WIDTH))    w_eff = EW_W'(MAX_WIDTH);
    else                                w_eff = EW_W'(w_raw);
  end
  assign wm1   = w_eff - EW_W'(1);
  assign h_eff = (image_height_r == '0) ? HGT_W'(1) : image_height_r;
  assign hm1   = h_eff - HGT_W'(1);

  // position counters and input/output lag
  logic [HGT_W-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [COL_W-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [LAG_W-1:0] lag_r, lag_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             accept, is_pixel, frame_done, restart;
  logic [HGT_W-1:0] cur_in_row, cur_out_row;
  logic [COL_W-1:0] cur_in_col, cur_out_col;
  logic [LAG_W-1:0] cur_lag, lag_thr;
  logic             emit_px, emit_dr, do_emit, wr_en;
  logic [EW_W-1:0]  in_col_inc, out_col_inc, xsum;
  logic [COL_W-1:0] xcol;
  pixel_t           wr_pix;
  emit_ctl_t        ctl0;
  logic             out_fire;

  assign in_tready  = (cnt_r < CNT_W'(FIFO_DEPTH));
  assign accept     = in_tvalid && in_tready;
  assign is_pixel   = !in_tuser;
  assign frame_done = (in_row_r >= h_eff);
  assign restart    = is_pixel && frame_done;

  assign cur_in_row  = restart ? '0 : in_row_r;
  assign cur_in_col  = restart ? '0 : in_col_r;
  assign cur_out_row = restart ? '0 : out_row_r;
  assign cur_out_col = restart ? '0 : out_col_r;
  assign cur_lag     = restart ? '0 : lag_r;
  assign lag_thr     = (LAG_W'(w_eff) << 1) + LAG_W'(KERNEL_RADIUS);

  assign emit_px = is_pixel && (cur_out_row < h_eff) && (cur_lag >= lag_thr);
  assign emit_dr = !is_pixel && frame_done && (out_row_r < h_eff);
  assign do_emit = accept && (emit_px || emit_dr);
  assign wr_en   = accept && is_pixel;
  assign wr_pix  = color_mode_r ? in_tdata : {16'b0, in_tdata[CH_W-1:0]};

  assign in_col_inc  = {1'b0, cur_in_col} + EW_W'(1);
  assign out_col_inc = {1'b0, cur_out_col} + EW_W'(1);

  always_comb begin
    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    lag_nxt     = lag_r;
    if (cfg_hit) begin
      in_row_nxt  = '0;
      in_col_nxt  = '0;
      out_row_nxt = '0;
      out_col_nxt = '0;
      lag_nxt     = '0;
    end else if (accept) begin
      in_row_nxt  = cur_in_row;
      in_col_nxt  = cur_in_col;
      out_row_nxt = cur_out_row;
      out_col_nxt = cur_out_col;
      lag_nxt     = cur_lag + LAG_W'(is_pixel) - LAG_W'(do_emit);
      if (is_pixel) begin
        if (in_col_inc == w_eff) begin
          in_col_nxt = '0;
          in_row_nxt = cur_in_row + HGT_W'(1);
        end else begin
          in_col_nxt = in_col_inc[COL_W-1:0];
        end
      end
      if (do_emit) begin
        if (out_col_inc == w_eff) begin
          out_col_nxt = '0;
          out_row_nxt = cur_out_row + HGT_W'(1);
        end else begin
          out_col_nxt = out_col_inc[COL_W-1:0];
        end
      end
    end
  end

  // outputs accepted but not yet taken
  assign cnt_nxt = cnt_r + CNT_W'(do_emit) - CNT_W'(out_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      lag_r     <= '0;
      cnt_r     <= '0;
    end else begin
      in_row_r  <= in_row_nxt;
      in_col_r  <= in_col_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
      lag_r     <= lag_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  // emit controls: newest window column and clamped ring rows
  logic [RW-1:0] rv;
  always_comb begin
    rv = '0;
    xsum = {1'b0, cur_out_col} + EW_W'(KERNEL_RADIUS);
    xcol = (xsum > wm1) ? wm1[COL_W-1:0] : xsum[COL_W-1:0];
    ctl0.first    = (cur_out_col == '0);
    ctl0.last     = (cur_out_row == hm1) && ({1'b0, cur_out_col} == wm1);
    ctl0.one_wide = (w_eff == EW_W'(1));
    for (int k = 0; k < KSIZE; k++) begin
      if (k < KERNEL_RADIUS && cur_out_row < HGT_W'(KERNEL_RADIUS - k)) begin
        rv = '0;
      end else begin
        rv = {1'b0, cur_out_row} + RW'(k) - RW'(KERNEL_RADIUS);
      end
      if (rv > {1'b0, hm1}) rv = {1'b0, hm1};
      ctl0.lanes[k] = rv[LANE_W-1:0];
    end
  end

  // line store: one column word holds all ring rows; lane write, word read
  column_t line_store [MAX_WIDTH];
  column_t rd_col_r;
  always_ff @(posedge clk) begin
    if (wr_en) line_store[cur_in_col][cur_in_row[LANE_W-1:0]] <= wr_pix;
    if (do_emit) rd_col_r <= line_store[xcol];
  end

  // columns 0 and 1 kept in flops for the row-start window
  column_t col0_r, col1_r;
  always_ff @(posedge clk) begin
    if (wr_en && cur_in_col == COL_W'(0)) col0_r[cur_in_row[LANE_W-1:0]] <= wr_pix;
    if (wr_en && cur_in_col == COL_W'(1)) col1_r[cur_in_row[LANE_W-1:0]] <= wr_pix;
  end

  // stage 1: forward the same-request write, sum columns
  logic             v1_r;
  emit_ctl_t        ctl1_r;
  logic [COL_W-1:0] xcol1_r, fwd_col1_r;
  logic             fwd_en1_r;
  logic [LANE_W-1:0] fwd_lane1_r;
  pixel_t           fwd_pix1_r;
  column_t          colx1;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= do_emit;
    ctl1_r      <= ctl0;
    xcol1_r     <= xcol;
    fwd_en1_r   <= wr_en;
    fwd_col1_r  <= cur_in_col;
    fwd_lane1_r <= cur_in_row[LANE_W-1:0];
    fwd_pix1_r  <= wr_pix;
  end

  always_comb begin
    colx1 = rd_col_r;
    if (fwd_en1_r && fwd_col1_r == xcol1_r) colx1[fwd_lane1_r] = fwd_pix1_r;
  end

  logic  v2_r, first2_r, last2_r;
  csum_t csx2_r, cs02_r, cs12_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    first2_r <= ctl1_r.first;
    last2_r  <= ctl1_r.last;
    csx2_r   <= col_sum(colx1, ctl1_r.lanes);
    cs02_r   <= col_sum(col0_r, ctl1_r.lanes);
    cs12_r   <= col_sum(ctl1_r.one_wide ? col0_r : col1_r, ctl1_r.lanes);
  end

  // stage 2: window of five column sums
  csum_t win_r [KSIZE];
  logic  v3_r, last3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    last3_r <= last2_r;
    if (v2_r) begin
      if (first2_r) begin
        for (int k = 0; k < KERNEL_RADIUS + 1; k++) win_r[k] <= cs02_r;
        win_r[KSIZE-2] <= cs12_r;
      end else begin
        for (int k = 0; k < KSIZE - 2; k++) win_r[k] <= win_r[k+1];
        win_r[KSIZE-2] <= win_r[KSIZE-1];
      end
      win_r[KSIZE-1] <= csx2_r;
    end
  end

  // stage 3: window total per channel
  logic [NCH-1:0][TSUM_W-1:0] tsum_r, tsum;
  logic v4_r, last4_r;
  always_comb begin
    tsum = '0;
    for (int c = 0; c < NCH; c++) begin
      for (int k = 0; k < KSIZE; k++) tsum[c] = tsum[c] + TSUM_W'(win_r[k][c]);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
    last4_r <= last3_r;
    tsum_r  <= tsum;
  end

  // stage 4: divide by 25 through reciprocal multiply, into the queue
  logic [2*TSUM_W-1:0] prod;
  out_ent_t            ent4;
  always_comb begin
    prod = '0;
    ent4.last = last4_r;
    for (int c = 0; c < NCH; c++) begin
      prod = tsum_r[c] * DIV_MUL;
      ent4.ch[c] = prod[DIV_SHIFT +: CH_W];
    end
  end

  // output queue
  out_ent_t         fifo_r [FIFO_DEPTH];
  logic [FIFO_AW:0] wptr_r, rptr_r;
  out_ent_t         head;

  assign out_tvalid = (wptr_r != rptr_r);
  assign out_fire   = out_tvalid && out_tready;
  assign head       = fifo_r[rptr_r[FIFO_AW-1:0]];
  assign out_tdata  = head.ch;
  assign out_tlast  = head.last;

  always_ff @(posedge clk) begin
    if (v4_r) fifo_r[wptr_r[FIFO_AW-1:0]] <= ent4;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
    end else begin
      if (v4_r)     wptr_r <= wptr_r + (FIFO_AW+1)'(1);
      if (out_fire) rptr_r <= rptr_r + (FIFO_AW+1)'(1);
    end
  end

endmodule

/* rtl/bf5_checker.sv */
// Port-level checker for the 5x5 box filter unit, bound to the top level.
// Depends on box_filter_5x5_replicate_unit_assert.svh.
`include "box_filter_5x5_replicate_unit_assert.svh"
module bf5_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_pready
);
  // requests stall only while results are queued
  `BF5_ASSERT_IMP(a_stall_has_result, !in_tready, out_tvalid, "input stalled with empty output")
  // a stalled result holds
  `BF5_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")
  // config port never waits
  `BF5_ASSERT_IMP(a_pready, 1'b1, cfg_pready, "cfg_pready low")
  // reset empties the output queue
  `BF5_ASSERT_RST(a_reset_empty, !rst_n, !out_tvalid, "output valid after reset")
endmodule

bind box_filter_5x5_replicate_unit bf5_checker u_bf5_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_pready (cfg_pready)
);

/* tb/tb_box_filter_5x5_replicate_unit.sv */
// Testbench for the 5x5 box filter: streams random frames through the unit
// and compares each result request with a cycle-free predictor. Needs bf5_pkg.
module tb_box_filter_5x5_replicate_unit;
  import bf5_pkg::*;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE = 12;

  typedef struct {
    logic [23:0] pix;
    logic        last;
  } mean_px_t;

  // predictor of the filter plus the store of expected mean pixels
  class mean_scoreboard;
    logic [23:0] rows[RING_ROWS*MAX_WIDTH];
    int unsigned width, height, color;
    int unsigned in_row, in_col, out_row, out_col;
    mean_px_t    pending[$];
    int          errors;

    function new();
      foreach (rows[i]) rows[i] = '0;
      width = 640; height = 480; color = 0;
      restart();
    endfunction

    function void restart();
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    endfunction

    function int unsigned eff_w();
      if (width < 1) return 1;
      if (width > MAX_WIDTH) return MAX_WIDTH;
      return width;
    endfunction

    function int unsigned eff_h();
      return (height == 0) ? 1 : height;
    endfunction

    function void reg_write(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_WIDTH: begin
          width = val[11:0];
        end
        REG_HEIGHT: begin
          height = val[15:0];
        end
        REG_COLOR: begin
          color = val[0];
        end
        default: return;
      endcase
      restart();
    endfunction

    // mean over the clamped 5x5 neighborhood of the next output position
    function void push_mean(int unsigned w, int unsigned h);
      int       sum[3];
      int       r, c;
      mean_px_t e;
      logic [23:0] px;
      sum = '{0, 0, 0};
      for (int dr = -2; dr <= 2; dr++) begin
        for (int dc = -2; dc <= 2; dc++) begin
          r = int'(out_row) + dr;
          c = int'(out_col) + dc;
          if (r < 0) r = 0;
          if (r > int'(h) - 1) r = int'(h) - 1;
          if (c < 0) c = 0;
          if (c > int'(w) - 1) c = int'(w) - 1;
          px = rows[(r % RING_ROWS) * MAX_WIDTH + c];
          for (int k = 0; k < 3; k++) sum[k] += px[8*k +: 8];
        end
      end
      e.pix[7:0]   = 8'(sum[0] / 25);
      e.pix[15:8]  = color ? 8'(sum[1] / 25) : 8'd0;
      e.pix[23:16] = color ? 8'(sum[2] / 25) : 8'd0;
      e.last = (out_row == h - 1) && (out_col == w - 1);
      pending.push_back(e);
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    endfunction

    // accepted input request
    function void note_input(logic func, logic [23:0] data);
      int unsigned w, h;
      longint      in_idx, out_idx;
      logic [23:0] px;
      w = eff_w();
      h = eff_h();
      if (func == FUNC_PIXEL) begin
        if (in_row >= h) restart();
        px = color ? data : {16'd0, data[7:0]};
        rows[(in_row % RING_ROWS) * MAX_WIDTH + in_col] = px;
        in_idx = longint'(in_row) * w + in_col;
        in_col++;
        if (in_col >= w) begin
          in_col = 0;
          in_row++;
        end
        out_idx = longint'(out_row) * w + out_col;
        if (out_row < h && in_idx >= out_idx + 2 * longint'(w) + 2) push_mean(w, h);
      end else if (in_row >= h && out_row < h) begin
        push_mean(w, h);
      end
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
    endtask

    // accepted result request
    task check(logic [23:0] data, logic last);
      mean_px_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected pixel", {7'd0, last, data}, 0);
        return;
      end
      e = pending.pop_front();
      if (data[7:0] !== e.pix[7:0]) report_mismatch("chan0", data[7:0], e.pix[7:0]);
      if (data[15:8] !== e.pix[15:8]) report_mismatch("chan1", data[15:8], e.pix[15:8]);
      if (data[23:16] !== e.pix[23:16])
        report_mismatch("chan2", data[23:16], e.pix[23:16]);
      if (last !== e.last) report_mismatch("frame_last", last, e.last);
    endtask
  endclass

  logic                clk = 0;
  logic                rst_n = 0;
  logic                in_tvalid = 0;
  logic                in_tready;
  logic [23:0]         in_tdata = '0;
  logic                in_tuser = 0;
  logic                out_tvalid;
  logic                out_tready = 1;
  logic [23:0]         out_tdata;
  logic                out_tlast;
  logic                cfg_psel = 0;
  logic                cfg_penable = 0;
  logic                cfg_pwrite = 0;
  logic [ADDR_W-1:0]   cfg_paddr = '0;
  logic [DATA_W-1:0]   cfg_pwdata = '0;
  logic [DATA_W-1:0]   cfg_prdata;
  logic                cfg_pready;

  mean_scoreboard sb = new();
  int  cycles = 0;
  int  out_stall = 0;
  bit  burst = 0;
  int  items = 0;

  box_filter_5x5_replicate_unit i_dut (.*);

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int draw_gap();
    return burst ? 0 : $urandom_range(0, 9);
  endfunction

  // result side: check and stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        sb.check(out_tdata, out_tlast);
        out_stall = draw_gap();
        if (out_stall > 0) out_tready <= 0;
      end else if (!out_tready) begin
        if (out_stall > 0) out_stall--;
        if (out_stall == 0) out_tready <= 1;
      end
    end
  end

  task automatic send(logic func, logic [23:0] data);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= func;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    sb.note_input(func, data);
    items++;
  endtask

  function automatic logic [23:0] rand_px();
    return 24'($urandom);
  endfunction

  task automatic wait_empty();
    in_tvalid <= 0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // one write; the bus then returns to idle
  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= ADDR_W'({idx, 2'b00}); cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 0; cfg_penable <= 0;
    sb.reg_write(idx, val);
    @(posedge clk);
  endtask

  task automatic apb_check(logic [1:0] idx, logic [31:0] want);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 0;
    cfg_paddr <= ADDR_W'({idx, 2'b00});
    @(posedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want) sb.report_mismatch("register read", cfg_prdata, want);
    cfg_psel <= 0; cfg_penable <= 0;
    @(posedge clk);
  endtask

  // idle first, then set all three registers and read them back
  task automatic setup(int unsigned w, int unsigned h, int unsigned col);
    wait_empty();
    apb_write(REG_WIDTH, w);
    apb_write(REG_HEIGHT, h);
    apb_write(REG_COLOR, col);
    apb_check(REG_WIDTH, w & 32'hFFF);
    apb_check(REG_HEIGHT, h & 32'hFFFF);
    apb_check(REG_COLOR, col & 1);
  endtask

  // one frame with random content; broken frames stop early
  task automatic frame(int unsigned w, int unsigned h, bit broken, bit pause);
    int unsigned n, ndrain;
    n = broken ? $urandom_range(1, w * h) : w * h;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send(FUNC_DRAIN, rand_px());
      if (pause && i == n / 2) wait_empty();
      send(FUNC_PIXEL, rand_px());
    end
    ndrain = ($urandom_range(0, 5) == 0) ? $urandom_range(0, w + 1)
                                          : 2 * w + 2 + $urandom_range(0, 3);
    repeat (ndrain) send(FUNC_DRAIN, rand_px());
  endtask

  initial begin
    int unsigned w, h;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: early drain, extreme pixels, new frame over a partly drained one
    setup(3, 2, 1);
    send(FUNC_DRAIN, 24'hFFFFFF);
    for (int i = 0; i < 6; i++) send(FUNC_PIXEL, (i % 2) ? 24'hFFFFFF : 24'h000000);
    repeat (2) send(FUNC_DRAIN, 24'h0);
    for (int i = 0; i < 6; i++) send(FUNC_PIXEL, (i < 3) ? 24'hFFFFFF : 24'h00FF00);
    repeat (8) send(FUNC_DRAIN, 24'h0);

    // register extremes: zero sizes, widest rows, clamped width, tall frame
    setup(0, 0, 0);
    frame(1, 1, 0, 0);
    setup(1, 1, 1);
    frame(1, 1, 0, 0);
    burst = 1;
    setup(2048, 1, 1);
    repeat (20) send(FUNC_PIXEL, rand_px());
    repeat (2) send(FUNC_DRAIN, rand_px());
    setup(4095, 2, 0);
    repeat (20) send(FUNC_PIXEL, rand_px());
    burst = 0;
    setup(7, 65535, 1);
    repeat (40) send(FUNC_PIXEL, rand_px());
    repeat (3) send(FUNC_DRAIN, rand_px());

    // random small frames
    while (items < 450) begin
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 5);
      burst = ($urandom_range(0, 3) == 0);
      setup(w, h, $urandom_range(0, 1));
      repeat ($urandom_range(1, 3))
        frame(w, h, $urandom_range(0, 6) == 0, $urandom_range(0, 7) == 0);
    end

    wait_empty();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* box_filter_5x5_replicate_unit.f */
+incdir+rtl
rtl/bf5_pkg.sv
rtl/box_filter_5x5_replicate_unit.sv
rtl/bf5_checker.sv
tb/tb_box_filter_5x5_replicate_unit.sv
